// ===== hdl/ffha_pkg.sv =====
// ffha_pkg: sizes, status and register codes and rounding helpers for the
// first-fit heap allocator.
// No dependencies; compile first.
package ffha_pkg;

  localparam int FREE_ENTRIES  = 32;
  localparam int ALLOC_ENTRIES = 32;
  localparam int PAGE_BYTES    = 4096;

  localparam int FX_W = $clog2(FREE_ENTRIES);
  localparam int FC_W = $clog2(FREE_ENTRIES + 1);
  localparam int AX_W = $clog2(ALLOC_ENTRIES);
  localparam int AC_W = $clog2(ALLOC_ENTRIES + 1);

  localparam logic [31:0] HDR_BYTES  = 32'd16;
  localparam logic [31:0] MIN_EXTENT = 32'd8;
  localparam logic [31:0] PAGE_M1    = 32'(PAGE_BYTES - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // (v + a - 1) & ~(a - 1), with am1 = a - 1
  function automatic logic [31:0] ffha_round(input logic [31:0] v, input logic [12:0] am1);
    logic [31:0] m;
    m = {19'd0, am1};
    return (v + m) & ~m;
  endfunction

  function automatic logic [31:0] ffha_page_up(input logic [31:0] v);
    return (v + PAGE_M1) & ~PAGE_M1;
  endfunction

endpackage

// ===== hdl/ffha_if.sv =====
// ffha channel interfaces: request, result and register write channels.
// Payload widths are fixed by the item fields; no dependencies.
interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] request_size;
  logic [12:0] alignment_bytes;
  logic [31:0] free_address;
  modport source(output valid, action, request_size, alignment_bytes, free_address,
                 input ready);
  modport sink(input valid, action, request_size, alignment_bytes, free_address,
               output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_address;
  logic [1:0]  status;
  logic [31:0] used_total;
  logic [31:0] mapped_total;
  modport source(output valid, payload_address, status, used_total, mapped_total,
                 input ready);
  modport sink(input valid, payload_address, status, used_total, mapped_total,
               output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/ffha_ram.sv =====
// ffha_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: first-fit allocator with coalescing free-extent table.
// Depends on ffha_pkg, ffha_if (channel interfaces) and ffha_ram.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    action, request_size, alignment_bytes, free_address
//   out_chan  out  valid/ready    payload_address, status, used_total, mapped_total
//   cfg_chan  in   valid/ready    index, data (ready always high)
//
// One item at a time; ready is high only while the sequencer is idle.
// An allocate walks every live free extent, plus one walk of the free table for
// each of the two re-inserts; if no extent fits, the break path tries the heap break.
// A free walks the allocated table and then makes one insert pass.
// Both tables sit in single-port-read RAMs, so every walk is one entry per step.
// Reset is synchronous; a register write re-initialises the heap.
// A finished result waits in the output register; the next item may be taken meanwhile.
module first_fit_heap_allocator import ffha_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  ffha_in_if.sink    in_chan,
  ffha_out_if.source out_chan,
  ffha_cfg_if.sink   cfg_chan
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_XRD, S_XLD, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_XEND, S_RM_RD, S_RM_WR, S_PFX, S_INS, S_INS_RD, S_INS_EV, S_INS_APPLY,
    S_INS_RM_RD, S_INS_RM_WR, S_INS_RET, S_BRK2, S_COMMIT, S_FREE_RD, S_FREE_EV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_SFX, RET_COMMIT, RET_FREE} ret_t;

  state_t st_r;
  ret_t   ret_r;

  logic [31:0] hs_r, hl_r, eff_start_r, eff_limit_r;
  logic [31:0] break_r, mapped_r, active_r;
  logic [FC_W-1:0] count_r, scan_r;
  logic [AC_W-1:0] ascan_r;
  logic [ALLOC_ENTRIES-1:0] vld_r;

  logic        act_r;
  logic [31:0] size_r, addr_r;
  logic [12:0] am1_r;
  logic        brk_r, found_r, lost_r;
  logic [AX_W-1:0] slot_r;

  logic [31:0] b_r, r1_r, hd_r, pl_r;
  logic [32:0] e_r, c16_r, ae_r;

  logic [FX_W-1:0] bidx_r;
  logic [31:0] bs_r, bhd_r, bpl_r;
  logic [32:0] bae_r, be_r;

  logic [31:0] ins_s_r, ins_len_r, ins_sl_r;
  logic        pf_r, nf_r;
  logic [FX_W-1:0] pidx_r, nidx_r;
  logic [31:0] ps_r, psum_r, nsum_r, nlen_r;

  logic [31:0] res_pay_r;
  logic [1:0]  res_stat_r;
  logic        out_valid_r;
  logic [31:0] out_pay_r, out_used_r, out_mapped_r;
  logic [1:0]  out_stat_r;

  // free-extent RAM: {length, start}
  logic            fx_we;
  logic [FX_W-1:0] fx_waddr, fx_raddr;
  logic [63:0]     fx_wdata, fx_rdata;
  // allocated-block RAM: {payload size, block size, header, payload}
  logic            al_we;
  logic [AX_W-1:0] al_raddr;
  logic [127:0]    al_wdata, al_rdata;

  logic [FC_W-1:0] cnt_m1;
  logic [FX_W-1:0] last_idx;
  logic [AX_W-1:0] fslot;
  logic            fslot_ok;
  logic [31:0]     x_start, x_len;
  logic [31:0]     prefix;
  logic [32:0]     suffix, ae_adj;
  logic [31:0]     new_start_eff, new_limit_eff, lim_page, start_page;

  ffha_ram #(.WIDTH(64), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(fx_we), .waddr(fx_waddr), .wdata(fx_wdata),
    .raddr(fx_raddr), .rdata(fx_rdata)
  );

  ffha_ram #(.WIDTH(128), .DEPTH(ALLOC_ENTRIES)) u_alloc_ram (
    .clk(clk), .we(al_we), .waddr(slot_r), .wdata(al_wdata),
    .raddr(al_raddr), .rdata(al_rdata)
  );

  assign in_chan.ready          = (st_r == S_IDLE);
  assign cfg_chan.ready         = 1'b1;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.payload_address = out_pay_r;
  assign out_chan.status        = out_stat_r;
  assign out_chan.used_total    = out_used_r;
  assign out_chan.mapped_total  = out_mapped_r;

  assign cnt_m1   = count_r - FC_W'(1);
  assign last_idx = cnt_m1[FX_W-1:0];
  assign x_start  = fx_rdata[31:0];
  assign x_len    = fx_rdata[63:32];
  assign prefix   = hd_r - b_r;
  assign suffix   = e_r - ae_r;
  assign ae_adj   = (suffix != 33'd0 && suffix < {1'b0, MIN_EXTENT}) ? e_r : ae_r;

  // first unused allocated-table slot
  always_comb begin
    fslot    = '0;
    fslot_ok = 1'b0;
    for (int i = ALLOC_ENTRIES - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        fslot    = AX_W'(i);
        fslot_ok = 1'b1;
      end
    end
  end

  // effective heap bounds for a register write
  always_comb begin
    start_page = ffha_page_up(cfg_chan.index == CFG_HEAP_START ? cfg_chan.data : hs_r);
    lim_page   = ffha_page_up(cfg_chan.index == CFG_HEAP_LIMIT ? cfg_chan.data : hl_r);
    new_start_eff = start_page;
    new_limit_eff = (lim_page <= start_page) ? start_page : lim_page;
  end

  always_comb begin
    fx_raddr = scan_r[FX_W-1:0];
    if (st_r == S_RM_RD || st_r == S_INS_RM_RD) begin
      fx_raddr = last_idx;
    end
    fx_we    = 1'b0;
    fx_waddr = count_r[FX_W-1:0];
    fx_wdata = {ins_len_r, ins_s_r};
    case (st_r)
      S_RM_WR: begin
        fx_we    = 1'b1;
        fx_waddr = bidx_r;
        fx_wdata = fx_rdata;
      end
      S_INS_RM_WR: begin
        fx_we    = 1'b1;
        fx_waddr = nidx_r;
        fx_wdata = fx_rdata;
      end
      S_INS_APPLY: begin
        if (pf_r) begin
          fx_we    = 1'b1;
          fx_waddr = pidx_r;
          fx_wdata = {psum_r + (nf_r ? nlen_r : 32'd0), ps_r};
        end else if (nf_r) begin
          fx_we    = 1'b1;
          fx_waddr = nidx_r;
          fx_wdata = {nsum_r, ins_s_r};
        end else if (count_r < FC_W'(FREE_ENTRIES)) begin
          fx_we    = 1'b1;
        end
      end
      default: begin
        fx_we = 1'b0;
      end
    endcase
  end

  assign al_raddr = ascan_r[AX_W-1:0];
  assign al_we    = (st_r == S_COMMIT);
  assign al_wdata = {size_r, bae_r[31:0] - bhd_r, bhd_r, bpl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ret_r       <= RET_FREE;
      hs_r        <= '0;
      hl_r        <= '0;
      eff_start_r <= '0;
      eff_limit_r <= '0;
      break_r     <= '0;
      mapped_r    <= '0;
      active_r    <= '0;
      count_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded below instead
      if (out_valid_r && out_chan.ready && st_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            act_r  <= in_chan.action;
            size_r <= in_chan.request_size;
            addr_r <= in_chan.free_address;
            am1_r  <= (in_chan.alignment_bytes == 13'd0) ? 13'd0
                                                         : in_chan.alignment_bytes - 13'd1;
            st_r   <= S_DECODE;
          end
        end
        S_DECODE: begin
          lost_r <= 1'b0;
          if (act_r == ACT_FREE) begin
            ascan_r <= '0;
            if (addr_r == 32'd0) begin
              res_pay_r  <= '0;
              res_stat_r <= ST_UNKNOWN;
              st_r       <= S_DONE;
            end else begin
              st_r <= S_FREE_RD;
            end
          end else if (size_r == 32'd0) begin
            res_pay_r  <= '0;
            res_stat_r <= ST_NO_SPACE;
            st_r       <= S_DONE;
          end else if (!fslot_ok) begin
            res_pay_r  <= '0;
            res_stat_r <= ST_FULL;
            st_r       <= S_DONE;
          end else begin
            slot_r  <= fslot;
            found_r <= 1'b0;
            brk_r   <= 1'b0;
            scan_r  <= '0;
            st_r    <= S_XRD;
          end
        end
        S_XRD: begin
          st_r <= (scan_r == count_r) ? S_XEND : S_XLD;
        end
        S_XLD: begin
          b_r   <= x_start;
          e_r   <= {1'b0, x_start} + {1'b0, x_len};
          c16_r <= {1'b0, x_start} + {1'b0, HDR_BYTES};
          // a fit at a lower address is already known
          if (found_r && x_start >= bs_r) begin
            scan_r <= scan_r + FC_W'(1);
            st_r   <= S_XRD;
          end else begin
            st_r <= S_P1;
          end
        end
        S_P1: begin
          r1_r <= ffha_round(c16_r[31:0], am1_r);
          st_r <= S_P2;
        end
        S_P2: begin
          hd_r <= (r1_r < b_r) ? b_r : r1_r;
          st_r <= S_P3;
        end
        S_P3: begin
          pl_r <= ffha_round(hd_r + HDR_BYTES, am1_r);
          st_r <= S_P4;
        end
        S_P4: begin
          // payload wrapped: fall back to header right below the first round-up
          if (pl_r < hd_r + HDR_BYTES) begin
            pl_r <= r1_r;
            hd_r <= r1_r - HDR_BYTES;
          end
          st_r <= S_P5;
        end
        S_P5: begin
          ae_r <= {1'b0, pl_r} + {1'b0, size_r};
          if (hd_r >= b_r && {1'b0, pl_r} >= {1'b0, hd_r} + {1'b0, HDR_BYTES}) begin
            st_r <= S_P6;
          end else if (brk_r) begin
            res_pay_r  <= '0;
            res_stat_r <= ST_NO_SPACE;
            st_r       <= S_DONE;
          end else begin
            scan_r <= scan_r + FC_W'(1);
            st_r   <= S_XRD;
          end
        end
        S_P6: begin
          if (ae_r > e_r) begin
            if (brk_r) begin
              res_pay_r  <= '0;
              res_stat_r <= ST_NO_SPACE;
              st_r       <= S_DONE;
            end else begin
              scan_r <= scan_r + FC_W'(1);
              st_r   <= S_XRD;
            end
          end else if (brk_r) begin
            st_r <= S_BRK2;
          end else if (prefix != 32'd0 && prefix < MIN_EXTENT) begin
            // sliver in front: header moves to the extent start
            if ({1'b0, r1_r} < c16_r) begin
              scan_r <= scan_r + FC_W'(1);
              st_r   <= S_XRD;
            end else begin
              hd_r <= b_r;
              pl_r <= r1_r;
              ae_r <= {1'b0, r1_r} + {1'b0, size_r};
              st_r <= S_P7;
            end
          end else begin
            st_r <= S_P8;
          end
        end
        S_P7: begin
          if (ae_r > e_r) begin
            scan_r <= scan_r + FC_W'(1);
            st_r   <= S_XRD;
          end else begin
            st_r <= S_P8;
          end
        end
        S_P8: begin
          found_r <= 1'b1;
          bidx_r  <= scan_r[FX_W-1:0];
          bs_r    <= b_r;
          bhd_r   <= hd_r;
          bpl_r   <= pl_r;
          bae_r   <= ae_adj;
          be_r    <= e_r;
          scan_r  <= scan_r + FC_W'(1);
          st_r    <= S_XRD;
        end
        S_XEND: begin
          if (found_r) begin
            if (bidx_r == last_idx) begin
              count_r <= cnt_m1;
              st_r    <= S_PFX;
            end else begin
              st_r <= S_RM_RD;
            end
          end else begin
            brk_r <= 1'b1;
            b_r   <= break_r;
            e_r   <= {1'b0, eff_limit_r};
            c16_r <= {1'b0, break_r} + {1'b0, HDR_BYTES};
            st_r  <= S_P1;
          end
        end
        S_RM_RD: begin
          st_r <= S_RM_WR;
        end
        S_RM_WR: begin
          count_r <= cnt_m1;
          st_r    <= S_PFX;
        end
        S_PFX: begin
          ins_s_r   <= bs_r;
          ins_len_r <= bhd_r - bs_r;
          ret_r     <= RET_SFX;
          st_r      <= S_INS;
        end
        S_INS: begin
          ins_sl_r <= ins_s_r + ins_len_r;
          pf_r     <= 1'b0;
          nf_r     <= 1'b0;
          scan_r   <= '0;
          st_r     <= (ins_len_r < MIN_EXTENT) ? S_INS_RET : S_INS_RD;
        end
        S_INS_RD: begin
          st_r <= (scan_r == count_r) ? S_INS_APPLY : S_INS_EV;
        end
        S_INS_EV: begin
          if (x_start + x_len == ins_s_r) begin
            pf_r   <= 1'b1;
            pidx_r <= scan_r[FX_W-1:0];
            ps_r   <= x_start;
            psum_r <= x_len + ins_len_r;
          end
          if (x_start == ins_sl_r) begin
            nf_r   <= 1'b1;
            nidx_r <= scan_r[FX_W-1:0];
            nlen_r <= x_len;
            nsum_r <= x_len + ins_len_r;
          end
          scan_r <= scan_r + FC_W'(1);
          st_r   <= S_INS_RD;
        end
        S_INS_APPLY: begin
          if (pf_r && nf_r) begin
            if (nidx_r == last_idx) begin
              count_r <= cnt_m1;
              st_r    <= S_INS_RET;
            end else begin
              st_r <= S_INS_RM_RD;
            end
          end else if (pf_r || nf_r) begin
            st_r <= S_INS_RET;
          end else begin
            if (count_r < FC_W'(FREE_ENTRIES)) begin
              count_r <= count_r + FC_W'(1);
            end else begin
              lost_r <= 1'b1;
            end
            st_r <= S_INS_RET;
          end
        end
        S_INS_RM_RD: begin
          st_r <= S_INS_RM_WR;
        end
        S_INS_RM_WR: begin
          count_r <= cnt_m1;
          st_r    <= S_INS_RET;
        end
        S_INS_RET: begin
          case (ret_r)
            RET_SFX: begin
              ins_s_r   <= bae_r[31:0];
              ins_len_r <= be_r[31:0] - bae_r[31:0];
              ret_r     <= RET_COMMIT;
              st_r      <= S_INS;
            end
            RET_COMMIT: begin
              st_r <= S_COMMIT;
            end
            default: begin
              res_pay_r  <= '0;
              res_stat_r <= lost_r ? ST_FULL : ST_OK;
              st_r       <= S_DONE;
            end
          endcase
        end
        S_BRK2: begin
          if (mapped_r < ffha_page_up(ae_r[31:0])) begin
            mapped_r <= ffha_page_up(ae_r[31:0]);
          end
          break_r <= ae_r[31:0];
          bhd_r   <= hd_r;
          bpl_r   <= pl_r;
          bae_r   <= ae_r;
          st_r    <= S_COMMIT;
        end
        S_COMMIT: begin
          vld_r[slot_r] <= 1'b1;
          active_r      <= active_r + size_r;
          res_pay_r     <= bpl_r;
          res_stat_r    <= lost_r ? ST_FULL : ST_OK;
          st_r          <= S_DONE;
        end
        S_FREE_RD: begin
          if (ascan_r == AC_W'(ALLOC_ENTRIES)) begin
            res_pay_r  <= '0;
            res_stat_r <= ST_UNKNOWN;
            st_r       <= S_DONE;
          end else if (!vld_r[ascan_r[AX_W-1:0]]) begin
            ascan_r <= ascan_r + AC_W'(1);
          end else begin
            st_r <= S_FREE_EV;
          end
        end
        S_FREE_EV: begin
          if (al_rdata[31:0] == addr_r) begin
            active_r  <= (active_r >= al_rdata[127:96]) ? active_r - al_rdata[127:96]
                                                        : 32'd0;
            vld_r[ascan_r[AX_W-1:0]] <= 1'b0;
            ins_s_r   <= al_rdata[63:32];
            ins_len_r <= al_rdata[95:64];
            ret_r     <= RET_FREE;
            st_r      <= S_INS;
          end else begin
            ascan_r <= ascan_r + AC_W'(1);
            st_r    <= S_FREE_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_pay_r    <= res_pay_r;
            out_stat_r   <= res_stat_r;
            out_used_r   <= active_r;
            out_mapped_r <= mapped_r - eff_start_r;
            st_r         <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
      // register write re-initialises the heap
      if (cfg_chan.valid &&
          (cfg_chan.index == CFG_HEAP_START || cfg_chan.index == CFG_HEAP_LIMIT)) begin
        if (cfg_chan.index == CFG_HEAP_START) begin
          hs_r <= cfg_chan.data;
        end else begin
          hl_r <= cfg_chan.data;
        end
        eff_start_r <= new_start_eff;
        eff_limit_r <= new_limit_eff;
        break_r     <= new_start_eff;
        mapped_r    <= new_start_eff;
        count_r     <= '0;
        active_r    <= '0;
        vld_r       <= '0;
      end
    end
  end

endmodule
